>>> rtl/core/tuning_table_key_mapper_core_defines.svh
// assertion macros for the tuning table key mapper core
// depends on nothing; files that check take it by include
`ifndef TUNING_TABLE_KEY_MAPPER_CORE_DEFINES_SVH
`define TUNING_TABLE_KEY_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// consequent holds in the same cycle as the trigger
`define TTKM_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);
// consequent holds in the cycle after the trigger
`define TTKM_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);
`else
`define TTKM_ASSERT_NOW(label, trig, cons, msg)
`define TTKM_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

>>> rtl/core/ttkm_pkg.sv
// shared types, constants and the divider step for the key mapper core
// depends on nothing
package ttkm_pkg;

  localparam int KEY_W      = 7;
  localparam int WIDTH_W    = 8;
  localparam int PERIOD_W   = 31;
  localparam int TONE_W     = 32;
  localparam int OUT_KEY_W  = 16;
  localparam int FRAC_W     = 25;
  localparam int PITCH_W    = 40;
  localparam int OCT_W      = 8;
  localparam int FRAC_SHIFT = 24;
  localparam int DIV_BITS   = 7;
  localparam int CFG_ADDR_W = 2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  localparam logic [FRAC_SHIFT-1:0] HALF_SEMI = 24'h800000;
  localparam logic [FRAC_W-1:0]     ONE_SEMI  = 25'h1000000;
  localparam logic signed [FRAC_W-1:0] FRAC_MAX = 25'sd8388608;
  localparam logic signed [FRAC_W-1:0] FRAC_MIN = -25'sd8388608;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ANCHOR_KEY  = 2'd0,
    CFG_TABLE_WIDTH = 2'd1,
    CFG_PERIOD_SIZE = 2'd2
  } cfg_reg_t;

  // item fields carried alongside the divider
  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  idx;
    logic [TONE_W-1:0] tone;
    logic              neg;
    logic              zw;
  } tag_t;

  // one divider stage: remainder, dividend bits shifting out, quotient shifting in
  typedef struct packed {
    logic                valid;
    logic [WIDTH_W-1:0]  rem;
    logic [DIV_BITS-1:0] aq;
    tag_t                tag;
  } div_t;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [WIDTH_W-1:0] index;
    logic [TONE_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic                       valid;
    logic                       has;
    logic signed [PITCH_W-1:0]  pitch;
  } acc_t;

  // one restoring division step, one quotient bit
  function automatic div_t div_step(div_t cur, logic [WIDTH_W-1:0] divisor);
    logic [WIDTH_W:0] trial;
    div_t             nxt;
    nxt   = cur;
    trial = {cur.rem, cur.aq[DIV_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      nxt.rem = WIDTH_W'(trial - {1'b0, divisor});
      nxt.aq  = {cur.aq[DIV_BITS-2:0], 1'b1};
    end else begin
      nxt.rem = trial[WIDTH_W-1:0];
      nxt.aq  = {cur.aq[DIV_BITS-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

>>> rtl/core/tuning_table_key_mapper_core.sv
// tuning table key mapper, top level: config registers and pipeline stages
// depends on ttkm_pkg, ttkm_div, ttkm_tone_mem, ttkm_round and the defines header
//
//   channel  handshake           payload
//   input    start / busy        in_kind in_key_number in_table_index in_tone_value
//   result   out_valid strobe    out_has_tone out_key out_pitch_fraction
//   config   cfg_we              cfg_addr cfg_wdata
//
// one beat enters per cycle; a map beat's result passes through the entry stage,
// the seven divider stages, then the fix, table, add and output stages
// load beats write the table in the table stage and give no result
// busy is high only during reset; the result side cannot stall, so nothing holds
// reset clears the table valid bits at once, no clearing pass
`include "tuning_table_key_mapper_core_defines.svh"

module tuning_table_key_mapper_core
  import ttkm_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [KEY_W-1:0]            in_key_number,
  input  logic [KEY_W-1:0]            in_table_index,
  input  logic signed [TONE_W-1:0]    in_tone_value,
  output logic                        out_valid,
  output logic                        out_has_tone,
  output logic signed [OUT_KEY_W-1:0] out_key,
  output logic signed [FRAC_W-1:0]    out_pitch_fraction,
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [PERIOD_W-1:0]         cfg_wdata
);

  // only table entries an index or a remainder below the key range can reach
  localparam int KEY_SPAN  = 2 ** KEY_W;
  localparam int EFF_DEPTH = (TABLE_DEPTH < KEY_SPAN) ? TABLE_DEPTH : KEY_SPAN;

  // config registers
  logic [KEY_W-1:0]    anchor_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [PERIOD_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
      width_r  <= WIDTH_W'(12);
      period_r <= PERIOD_W'(201326592);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_ANCHOR_KEY:  anchor_r <= cfg_wdata[KEY_W-1:0];
        CFG_TABLE_WIDTH: width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_PERIOD_SIZE: period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // never stalls; held off only while in reset
  assign busy = ~rst_n;

  // entry stage
  logic              en_valid_r;
  logic              en_kind_r;
  logic [KEY_W-1:0]  en_key_r;
  logic [KEY_W-1:0]  en_idx_r;
  logic [TONE_W-1:0] en_tone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_valid_r <= 1'b0;
    end else begin
      en_valid_r <= start & ~busy;
    end
    en_kind_r <= in_kind;
    en_key_r  <= in_key_number;
    en_idx_r  <= in_table_index;
    en_tone_r <= in_tone_value;
  end

  // distance from anchor, split into sign and magnitude for the divider
  logic [KEY_W:0] key_diff;
  logic [KEY_W:0] dist_mag;
  div_t           div_in;
  div_t           div_out;

  assign key_diff = {1'b0, en_key_r} - {1'b0, anchor_r};
  assign dist_mag = key_diff[KEY_W] ? (~key_diff + 1'b1) : key_diff;

  always_comb begin
    div_in.valid    = en_valid_r;
    div_in.rem      = '0;
    div_in.aq       = dist_mag[DIV_BITS-1:0];
    div_in.tag.kind = en_kind_r;
    div_in.tag.idx  = en_idx_r;
    div_in.tag.tone = en_tone_r;
    div_in.tag.neg  = key_diff[KEY_W];
    div_in.tag.zw   = (width_r == '0);
  end

  ttkm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .divisor (width_r),
    .div_in  (div_in),
    .div_out (div_out)
  );

  // fix stage: turn the magnitude result into floored octave and slot
  logic                     fx_valid_r;
  logic                     fx_kind_r;
  logic [KEY_W-1:0]         fx_idx_r;
  logic [TONE_W-1:0]        fx_tone_r;
  logic                     fx_zw_r;
  logic signed [OCT_W-1:0]  fx_oct_r, fx_oct_nxt;
  logic [WIDTH_W-1:0]       fx_slot_r, fx_slot_nxt;
  logic [OCT_W-1:0]         quo_ext;

  assign quo_ext = {1'b0, div_out.aq};

  always_comb begin
    if (!div_out.tag.neg) begin
      fx_oct_nxt  = $signed(quo_ext);
      fx_slot_nxt = div_out.rem;
    end else if (div_out.rem == '0) begin
      fx_oct_nxt  = -$signed(quo_ext);
      fx_slot_nxt = '0;
    end else begin
      // negative distance with remainder: one octave further down
      fx_oct_nxt  = ~$signed(quo_ext);
      fx_slot_nxt = width_r - div_out.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_valid_r <= 1'b0;
    end else begin
      fx_valid_r <= div_out.valid;
    end
    fx_kind_r <= div_out.tag.kind;
    fx_idx_r  <= div_out.tag.idx;
    fx_tone_r <= div_out.tag.tone;
    fx_zw_r   <= div_out.tag.zw;
    fx_oct_r  <= fx_oct_nxt;
    fx_slot_r <= fx_slot_nxt;
  end

  // table stage: loads write, maps read; period times octave in parallel
  mem_req_t                  mem_req;
  logic [TONE_W-1:0]         rd_data;
  logic                      rd_hit;
  logic                      idx_ok;
  logic                      slot_ok;
  logic signed [PITCH_W-1:0] mul_a, mul_b;
  logic                      ms_valid_r;
  logic                      ms_live_r;
  logic signed [PITCH_W-1:0] ms_prod_r;

  assign idx_ok  = 32'(fx_idx_r) < EFF_DEPTH;
  assign slot_ok = 32'(fx_slot_r) < EFF_DEPTH;

  always_comb begin
    mem_req.wr_en = fx_valid_r && (fx_kind_r == KIND_LOAD) && idx_ok;
    mem_req.rd_en = fx_valid_r && (fx_kind_r == KIND_MAP) && slot_ok && !fx_zw_r;
    mem_req.index = (fx_kind_r == KIND_LOAD) ? WIDTH_W'(fx_idx_r) : fx_slot_r;
    mem_req.wdata = fx_tone_r;
  end

  ttkm_tone_mem #(
    .EFF_DEPTH (EFF_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data),
    .rd_hit  (rd_hit)
  );

  assign mul_a = PITCH_W'($signed({1'b0, period_r}));
  assign mul_b = PITCH_W'(fx_oct_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_valid_r <= 1'b0;
    end else begin
      ms_valid_r <= fx_valid_r && (fx_kind_r == KIND_MAP);
    end
    ms_live_r <= mem_req.rd_en;
    ms_prod_r <= mul_a * mul_b;
  end

  // add stage: pitch = period * octave + tone; zero entry or miss means no tone
  logic                      ad_valid_r;
  logic                      ad_has_r;
  logic signed [PITCH_W-1:0] ad_pitch_r;
  logic                      has_nxt;
  acc_t                      acc;

  assign has_nxt = ms_live_r && rd_hit && (rd_data != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_valid_r <= 1'b0;
    end else begin
      ad_valid_r <= ms_valid_r;
    end
    ad_has_r   <= has_nxt;
    ad_pitch_r <= ms_prod_r + PITCH_W'($signed(rd_data));
  end

  assign acc.valid = ad_valid_r;
  assign acc.has   = ad_has_r;
  assign acc.pitch = ad_pitch_r;

  // output stage
  ttkm_round u_round (
    .clk                (clk),
    .rst_n              (rst_n),
    .acc                (acc),
    .out_valid          (out_valid),
    .out_has_tone       (out_has_tone),
    .out_key            (out_key),
    .out_pitch_fraction (out_pitch_fraction)
  );

  // checks
  `TTKM_ASSERT_NEXT(a_map_advances, ms_valid_r, ad_valid_r, "map beat lost after table stage")
  `TTKM_ASSERT_NOW(a_no_tone_zero, out_valid && !out_has_tone, (out_key == '0) && (out_pitch_fraction == '0), "no-tone result not zero")
  `TTKM_ASSERT_NOW(a_frac_bound, out_valid, (out_pitch_fraction <= FRAC_MAX) && (out_pitch_fraction >= FRAC_MIN), "fraction beyond half a semitone")

endmodule

>>> rtl/core/ttkm_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ttkm_pkg
module ttkm_div
  import ttkm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WIDTH_W-1:0] divisor,
  input  div_t               div_in,
  output div_t               div_out
);

  div_t stage_r [DIV_BITS];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
    div_t stage_nxt;
    if (i == 0) begin : g_first
      assign stage_nxt = div_step(div_in, divisor);
    end else begin : g_rest
      assign stage_nxt = div_step(stage_r[i-1], divisor);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i] <= '0;
      end else begin
        stage_r[i] <= stage_nxt;
      end
    end
  end

  assign div_out = stage_r[DIV_BITS-1];

endmodule

>>> rtl/core/ttkm_tone_mem.sv
// tone table: single write port, registered read, valid bit per entry
// depends on ttkm_pkg
module ttkm_tone_mem
  import ttkm_pkg::*;
#(
  parameter int EFF_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_req_t          req,
  output logic [TONE_W-1:0] rd_data,
  output logic              rd_hit
);

  localparam int ADDR_W = (EFF_DEPTH > 1) ? $clog2(EFF_DEPTH) : 1;

  logic [TONE_W-1:0]    mem [EFF_DEPTH];
  logic [EFF_DEPTH-1:0] vld_r;
  logic [TONE_W-1:0]    rd_data_r;
  logic                 rd_hit_r;
  logic [ADDR_W-1:0]    addr;

  assign addr = ADDR_W'(req.index);

  // entries never written read as no tone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[addr];
      rd_hit_r  <= vld_r[addr];
    end
  end

  assign rd_data = rd_data_r;
  assign rd_hit  = rd_hit_r;

endmodule

>>> rtl/core/ttkm_round.sv
// output stage: nearest key with folded fraction, key saturation
// depends on ttkm_pkg
module ttkm_round
  import ttkm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  acc_t                        acc,
  output logic                        out_valid,
  output logic                        out_has_tone,
  output logic signed [OUT_KEY_W-1:0] out_key,
  output logic signed [FRAC_W-1:0]    out_pitch_fraction
);

  logic                  valid_r;
  logic                  has_r;
  logic [OUT_KEY_W-1:0]  key_r, key_nxt;
  logic [FRAC_W-1:0]     frac_r, frac_nxt;
  logic [FRAC_SHIFT-1:0] low;
  logic [OUT_KEY_W-1:0]  whole;
  logic                  up;
  logic [OUT_KEY_W:0]    key_wide;

  assign low   = acc.pitch[FRAC_SHIFT-1:0];
  assign whole = acc.pitch[PITCH_W-1:FRAC_SHIFT];
  // exact half stays on the truncated key, which is one up for negative pitch
  assign up    = (low > HALF_SEMI) || ((low == HALF_SEMI) && acc.pitch[PITCH_W-1]);
  assign key_wide = {whole[OUT_KEY_W-1], whole} + (OUT_KEY_W+1)'(up);

  always_comb begin
    key_nxt  = '0;
    frac_nxt = '0;
    if (acc.has) begin
      frac_nxt = up ? (FRAC_W'(low) - ONE_SEMI) : FRAC_W'(low);
      if (key_wide[OUT_KEY_W:OUT_KEY_W-1] == 2'b01) begin
        key_nxt = {1'b0, {(OUT_KEY_W-1){1'b1}}};
      end else begin
        key_nxt = key_wide[OUT_KEY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc.valid;
    end
    has_r  <= acc.has;
    key_r  <= key_nxt;
    frac_r <= frac_nxt;
  end

  assign out_valid          = valid_r;
  assign out_has_tone       = has_r;
  assign out_key            = $signed(key_r);
  assign out_pitch_fraction = $signed(frac_r);

endmodule

>>> tb/sv/tuning_table_key_mapper_core_tb.sv
// testbench for the tuning table key mapper core: load and map beats go in,
// every map result is predicted from a private table copy and checked on its strobe
// depends on ttkm_pkg and tuning_table_key_mapper_core
module tuning_table_key_mapper_core_tb;
  import ttkm_pkg::*;

  localparam int     DEPTH           = 128;
  localparam longint SEMITONE        = 64'sd16777216;
  localparam longint HALF_STEP       = 64'sd8388608;
  localparam int     N_PHASES        = 12;
  localparam int     BEATS_PER_PHASE = 145;
  // load beats leave no trace, so wait longer than a map beat takes to come out
  localparam int     DRAIN_CYCLES    = 16;
  localparam int     CYCLE_LIMIT     = 200000;

  // expected content of one result strobe
  typedef struct packed {
    logic                        has;
    logic signed [OUT_KEY_W-1:0] key;
    logic signed [FRAC_W-1:0]    frac;
  } pitch_t;

  // private copy of the tone table and registers, plus the queue of pending pitches
  class pitch_map_tracker;
    logic [TONE_W-1:0]   tone_tbl [DEPTH];
    logic [KEY_W-1:0]    anchor;
    logic [WIDTH_W-1:0]  width;
    logic [PERIOD_W-1:0] period;
    pitch_t              expected_pitches [$];
    int                  errors;

    function new();
      foreach (tone_tbl[i]) tone_tbl[i] = '0;
      anchor = '0;
      width  = 8'd12;
      period = 31'd201326592;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [PERIOD_W-1:0] v);
      case (r)
        CFG_ANCHOR_KEY:  anchor = v[KEY_W-1:0];
        CFG_TABLE_WIDTH: width = v[WIDTH_W-1:0];
        CFG_PERIOD_SIZE: period = v;
        default: ;
      endcase
    endfunction

    // floored octave and slot, pitch = period * octave + tone, then nearest key
    function pitch_t map_key_to_pitch(logic [KEY_W-1:0] key_num);
      longint key_diff, wd, octave, slot, tone, pitch_units, whole, frac;
      pitch_t r;
      r  = '0;
      wd = longint'(width);
      if (wd == 0) return r;
      key_diff = longint'(key_num) - longint'(anchor);
      octave   = key_diff / wd;
      slot     = key_diff % wd;
      if (slot < 0) begin
        slot   += wd;
        octave -= 1;
      end
      if (slot >= DEPTH) return r;
      if (tone_tbl[slot] == '0) return r;
      tone        = longint'($signed(tone_tbl[slot]));
      pitch_units = longint'(period) * octave + tone;
      whole       = pitch_units / SEMITONE;
      frac        = pitch_units - whole * SEMITONE;
      // exactly half stays where it is
      if (frac < -HALF_STEP) begin
        frac  += SEMITONE;
        whole -= 1;
      end else if (frac > HALF_STEP) begin
        frac  -= SEMITONE;
        whole += 1;
      end
      if (whole > 32767) whole = 32767;
      else if (whole < -32768) whole = -32768;
      r.has  = 1'b1;
      r.key  = whole[OUT_KEY_W-1:0];
      r.frac = frac[FRAC_W-1:0];
      return r;
    endfunction

    function void note_beat(logic kind, logic [KEY_W-1:0] key_num,
                            logic [KEY_W-1:0] idx, logic [TONE_W-1:0] tone);
      if (kind == KIND_LOAD) begin
        if (idx < DEPTH) tone_tbl[idx] = tone;
      end else begin
        expected_pitches.push_back(map_key_to_pitch(key_num));
      end
    endfunction

    task report_mismatch(string msg);
      $display("error: %s", msg);
      errors++;
    endtask

    task check_result(logic has, logic signed [OUT_KEY_W-1:0] key,
                      logic signed [FRAC_W-1:0] frac);
      pitch_t want;
      if (expected_pitches.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: has=%0b key=%0d frac=%0d",
                                  has, key, frac));
      end else begin
        want = expected_pitches.pop_front();
        if (has !== want.has)
          report_mismatch($sformatf("has_tone got %0b want %0b", has, want.has));
        if (key !== want.key)
          report_mismatch($sformatf("out_key got %0d want %0d", key, want.key));
        if (frac !== want.frac)
          report_mismatch($sformatf("pitch_fraction got %0d want %0d", frac, want.frac));
      end
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_kind;
  logic [KEY_W-1:0]            in_key_number;
  logic [KEY_W-1:0]            in_table_index;
  logic signed [TONE_W-1:0]    in_tone_value;
  logic                        out_valid;
  logic                        out_has_tone;
  logic signed [OUT_KEY_W-1:0] out_key;
  logic signed [FRAC_W-1:0]    out_pitch_fraction;
  logic                        cfg_we;
  cfg_reg_t                    cfg_addr;
  logic [PERIOD_W-1:0]         cfg_wdata;

  pitch_map_tracker tracker;
  int               burst_left  = 0;
  int               cycle_count = 0;

  tuning_table_key_mapper_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_key_number      (in_key_number),
    .in_table_index     (in_table_index),
    .in_tone_value      (in_tone_value),
    .out_valid          (out_valid),
    .out_has_tone       (out_has_tone),
    .out_key            (out_key),
    .out_pitch_fraction (out_pitch_fraction),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // result side cannot be stalled: every strobe is a beat to check
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      tracker.check_result(out_has_tone, out_key, out_pitch_fraction);
  end

  // hard stop if the block hangs or drops results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // bursts of random length, random gaps between them, some bursts back to back
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // hold the beat until an edge with start high and busy low
  task automatic send_beat(logic kind, logic [KEY_W-1:0] key_num,
                           logic [KEY_W-1:0] idx, logic [TONE_W-1:0] tone);
    pace_sender();
    start          <= 1'b1;
    in_kind        <= kind;
    in_key_number  <= key_num;
    in_table_index <= idx;
    in_tone_value  <= tone;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_beat(kind, key_num, idx, tone);
  endtask

  // unused fields carry random noise
  task automatic load_tone(logic [KEY_W-1:0] idx, logic [TONE_W-1:0] tone);
    send_beat(KIND_LOAD, KEY_W'($urandom()), idx, tone);
  endtask

  task automatic map_key(logic [KEY_W-1:0] key_num);
    send_beat(KIND_MAP, key_num, KEY_W'($urandom()), TONE_W'($urandom()));
  endtask

  // all maps answered, then room for trailing load beats to retire
  task automatic wait_idle();
    start <= 1'b0;
    while (tracker.expected_pitches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all three registers on consecutive edges
  task automatic apply_setting(logic [KEY_W-1:0] anchor, logic [WIDTH_W-1:0] width,
                               logic [PERIOD_W-1:0] period);
    cfg_reg_t            regs [3];
    logic [PERIOD_W-1:0] vals [3];
    regs = '{CFG_ANCHOR_KEY, CFG_TABLE_WIDTH, CFG_PERIOD_SIZE};
    vals = '{PERIOD_W'(anchor), PERIOD_W'(width), period};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly raw values, some zero, some whole semitones exact, at or just past one half off
  function automatic logic [TONE_W-1:0] pick_tone();
    longint semis, offset;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: begin
        semis = longint'($urandom_range(0, 255)) - 128;
        case ($urandom_range(0, 4))
          0:       offset = HALF_STEP;
          1:       offset = -HALF_STEP;
          2:       offset = HALF_STEP + 1;
          3:       offset = -HALF_STEP - 1;
          default: offset = 0;
        endcase
        return TONE_W'(semis * SEMITONE + offset);
      end
      default: return TONE_W'($urandom());
    endcase
  endfunction

  // loads aim mostly at slots the current width reaches, the rest anywhere
  task automatic random_beat();
    int span;
    span = (tracker.width == 0 || tracker.width > DEPTH) ? DEPTH : int'(tracker.width);
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 4) == 0) load_tone(KEY_W'($urandom_range(0, DEPTH - 1)), pick_tone());
      else load_tone(KEY_W'($urandom_range(0, span - 1)), pick_tone());
    end else begin
      map_key(KEY_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    logic [KEY_W-1:0]    anchor_sel;
    logic [WIDTH_W-1:0]  width_sel;
    logic [PERIOD_W-1:0] period_sel;
    tracker = new();

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_kind        <= KIND_LOAD;
    in_key_number  <= '0;
    in_table_index <= '0;
    in_tone_value  <= '0;
    cfg_we         <= 1'b0;
    cfg_addr       <= CFG_ANCHOR_KEY;
    cfg_wdata      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings: anchor 0, 12 slots, 12 semitone period
    map_key(7'd0);                                  // empty table gives no tone
    load_tone(7'd0, TONE_W'(HALF_STEP));            // exactly half up is kept
    map_key(7'd0);
    load_tone(7'd1, TONE_W'(-HALF_STEP));           // exactly half down is kept
    map_key(7'd1);
    load_tone(7'd2, TONE_W'(HALF_STEP + 1));        // just past half folds up
    map_key(7'd2);
    load_tone(7'd3, TONE_W'(-HALF_STEP - 1));       // just past half folds down
    map_key(7'd3);
    load_tone(7'd4, 32'h7fffffff);                  // largest tone, low and top octave
    map_key(7'd4);
    map_key(7'd124);
    load_tone(7'd5, 32'h80000000);                  // most negative tone
    map_key(7'd5);
    map_key(7'd125);
    load_tone(7'd127, 32'h00000001);                // top index, outside the used width
    map_key(7'd127);
    load_tone(7'd11, 32'hffffffff);                 // tone of minus one unit
    map_key(7'd11);
    map_key(7'd23);
    load_tone(7'd0, '0);                            // zero entry clears the tone
    map_key(7'd0);

    // phase 0 keeps reset settings, then extremes, then random settings
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: begin anchor_sel = 7'd60;  width_sel = 8'd12;  period_sel = 31'd201326592; end
          2: begin anchor_sel = 7'd0;   width_sel = 8'd1;   period_sel = 31'h7fffffff;  end
          3: begin anchor_sel = 7'd127; width_sel = 8'd128; period_sel = '0;            end
          // zero width answers no tone for every map
          4: begin anchor_sel = 7'd127; width_sel = 8'd0;   period_sel = PERIOD_W'($urandom()); end
          5: begin anchor_sel = 7'd64;  width_sel = 8'd7;   period_sel = 31'd117440515; end
          // widths past the table depth reach slots that read as no tone
          6: begin anchor_sel = 7'd20;  width_sel = 8'd200; period_sel = 31'd318767104; end
          7: begin anchor_sel = 7'd100; width_sel = 8'd255; period_sel = 31'h7fffffff;  end
          default: begin
            anchor_sel = KEY_W'($urandom_range(0, 127));
            width_sel  = WIDTH_W'($urandom_range(1, 128));
            if ($urandom_range(0, 1) == 0)
              period_sel = PERIOD_W'(longint'($urandom_range(1, 24)) * SEMITONE);
            else
              period_sel = PERIOD_W'($urandom());
          end
        endcase
        apply_setting(anchor_sel, width_sel, period_sel);
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) random_beat();
    end

    wait_idle();
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
